@@ hdl/avm_pkg.sv @@
// adsr voice mixer: shared constants, sequencer states and the quarter-wave sine table
// used by avm_divider and adsr_voice_mixer; no dependencies
package avm_pkg;

  localparam int VOICES      = 8;
  localparam int SAMPLE_RATE = 48000;
  localparam int SINE_DEPTH  = 256;
  localparam int SEG_BITS    = 20;

  localparam int VIDX_W    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int POS_W     = SEG_BITS + 2;
  localparam int RATE_W    = $clog2(SAMPLE_RATE + 1);
  localparam int HALF_RATE = SAMPLE_RATE / 2;
  localparam int DEN_W     = (SEG_BITS > RATE_W) ? SEG_BITS : RATE_W;
  localparam int MUL_A_W   = (SEG_BITS > 16) ? SEG_BITS : 16;
  localparam int NUM_W     = MUL_A_W + 16;
  localparam int ACC_W     = 17 + VIDX_W;
  localparam int SINE_BITS = $clog2(SINE_DEPTH);

  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_START = 1'b1;
  localparam logic WAVE_SINE  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RATE_DIV,
    ST_STEP_DIV,
    ST_SCAN,
    ST_ENV,
    ST_ENV_MUL,
    ST_ENV_DIV,
    ST_WAVE,
    ST_SINE,
    ST_PAN,
    ST_ACCUM,
    ST_OUT
  } state_e;

  typedef logic [14:0] sine_tab_t [SINE_DEPTH + 1];

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // (2k)(2k+1) for the taylor terms k = 1..6
  localparam longint unsigned TAYLOR_DEN [6] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                 64'd110, 64'd156};

  // q30 taylor series up to x^13, rounded to unsigned q0.15
  function automatic sine_tab_t build_sine();
    sine_tab_t       tab;
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    longint          v;
    for (int i = 0; i <= SINE_DEPTH; i++) begin
      x    = (HALF_PI_Q30 * longint'(i)) / SINE_DEPTH;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 6; k++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / TAYLOR_DEN[k - 1];
        if ((k & 1) == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
      if (v > 32767) v = 32767;
      tab[i] = 15'(v);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

endpackage

@@ hdl/avm_divider.sv @@
// restoring radix-2 unsigned divider, one quotient bit per cycle
// depends on avm_pkg for operand widths
module avm_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [avm_pkg::NUM_W-1:0]  dividend_i,
  input  logic [avm_pkg::DEN_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [avm_pkg::NUM_W-1:0]  quotient_o
);

  localparam int CNT_W = $clog2(avm_pkg::NUM_W + 1);

  logic                      run_q, done_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [avm_pkg::NUM_W-1:0] num_q;
  logic [avm_pkg::DEN_W-1:0] den_q, rem_q, rem_d;
  logic [avm_pkg::DEN_W:0]   rem_sh, rem_sub;
  logic                      fits;
  logic                      last;

  always_comb begin
    rem_sh  = {rem_q, num_q[avm_pkg::NUM_W-1]};
    fits    = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
    rem_d   = fits ? rem_sub[avm_pkg::DEN_W-1:0] : rem_sh[avm_pkg::DEN_W-1:0];
    last    = cnt_q == CNT_W'(avm_pkg::NUM_W - 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (run_q) begin
      num_q <= {num_q[avm_pkg::NUM_W-2:0], fits};
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;

endmodule

@@ hdl/adsr_voice_mixer.sv @@
// polyphonic adsr voice mixer: voice registers, sequencer, shared multiplier
// depends on avm_pkg and avm_divider
//
//  channel  | signals                                   | transfer
//  ---------+-------------------------------------------+------------------------------
//  command  | start, busy, func_i .. balance_i          | start high and busy low
//  result   | result_valid_o, left/right_sample_o       | strobe, one cycle, no stall
//
// a start command holds busy while two quotients go through the shared divider,
// one for the sample period and one for the phase step.
// a tick holds busy while the sequencer walks the voice slots: an idle slot is skipped,
// an ending voice is cleared, a holding voice skips the divider and a ramping voice waits
// on the divider for its ramp segment (sine adds ST_SINE); the strobe rises as busy drops.
// reset clears the sequencer and every voice's active flag, position and phase.
// the receiver cannot stall; each result is a one-cycle strobe.
module adsr_voice_mixer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                func_i,
  input  logic [2:0]          voice_i,
  input  logic                waveform_i,
  input  logic [14:0]         frequency_i,
  input  logic [14:0]         peak_i,
  input  logic [14:0]         base_i,
  input  logic [19:0]         attack_len_i,
  input  logic [19:0]         decay_len_i,
  input  logic [19:0]         sustain_len_i,
  input  logic [19:0]         release_len_i,
  input  logic signed [15:0]  balance_i,
  output logic                result_valid_o,
  output logic signed [15:0]  left_sample_o,
  output logic signed [15:0]  right_sample_o
);

  localparam int VOICES   = avm_pkg::VOICES;
  localparam int VIDX_W   = avm_pkg::VIDX_W;
  localparam int POS_W    = avm_pkg::POS_W;
  localparam int SEG_BITS = avm_pkg::SEG_BITS;
  localparam int NUM_W    = avm_pkg::NUM_W;
  localparam int DEN_W    = avm_pkg::DEN_W;
  localparam int MUL_A_W  = avm_pkg::MUL_A_W;
  localparam int ACC_W    = avm_pkg::ACC_W;
  localparam int SB       = avm_pkg::SINE_BITS;

  // voice storage
  logic                active_q [VOICES];
  logic [POS_W-1:0]    pos_q    [VOICES];
  logic [31:0]         phase_q  [VOICES];
  logic [31:0]         step_q   [VOICES];
  logic                shape_q  [VOICES];
  logic [14:0]         peak_q   [VOICES];
  logic [14:0]         base_q   [VOICES];
  logic [SEG_BITS-1:0] alen_q   [VOICES];
  logic [SEG_BITS-1:0] dlen_q   [VOICES];
  logic [SEG_BITS-1:0] slen_q   [VOICES];
  logic [SEG_BITS-1:0] rlen_q   [VOICES];
  logic [15:0]         weight_q [VOICES];

  avm_pkg::state_e state_q, state_d;
  logic [VIDX_W-1:0]   idx_q;
  logic                last_voice;

  // per-voice working registers
  logic [SEG_BITS-1:0] off_q, len_q;
  logic [14:0]         mag_q, env0_q, amp_q, smag_q;
  logic                neg_q, sneg_q;
  logic [NUM_W-1:0]    prod_q;
  logic signed [ACC_W-1:0] accl_q, accr_q;
  logic                strobe_q;
  logic signed [15:0]  left_q, right_q;

  // shared units
  logic                div_start, div_done;
  logic [NUM_W-1:0]    div_num, div_quot;
  logic [DEN_W-1:0]    div_den;
  logic [MUL_A_W-1:0]  mul_a;
  logic [15:0]         mul_b;
  logic [NUM_W-1:0]    mul_out;

  logic                accept, start_ok;
  logic [DEN_W-1:0]    f_sat;
  logic signed [16:0]  bal_ext;
  logic [15:0]         weight_in;

  // envelope decode for the current slot
  logic [POS_W-1:0]    cur_p, sum_ad, sum_ads, sum_all;
  logic                env_ramp, env_hold, env_end;
  logic [SEG_BITS-1:0] env_off, env_len;
  logic [14:0]         env_mag, env_start;
  logic                env_neg;

  // sine lookup
  logic [31:0]         cur_ph;
  logic [SB-1:0]       sk;
  logic [SB:0]         tidx;
  logic [14:0]         tval;

  logic [14:0]         amp_div;
  logic signed [ACC_W-1:0] smp_s, part_s;
  logic [14:0]         pmag;

  avm_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign mul_out = NUM_W'(mul_a) * NUM_W'(mul_b);

  always_comb begin
    accept   = start && !busy;
    start_ok = 32'(voice_i) < 32'(VOICES);
    if (frequency_i == 15'd0) f_sat = DEN_W'(1);
    else if (32'(frequency_i) > 32'(avm_pkg::HALF_RATE)) f_sat = DEN_W'(avm_pkg::HALF_RATE);
    else f_sat = DEN_W'(frequency_i);
    bal_ext   = (balance_i == -16'sd32768) ? -17'sd32767 : 17'(balance_i);
    weight_in = 16'(bal_ext + 17'sd32767);
    last_voice = idx_q == VIDX_W'(VOICES - 1);
  end

  always_comb begin
    cur_p   = pos_q[idx_q];
    sum_ad  = POS_W'(alen_q[idx_q]) + POS_W'(dlen_q[idx_q]);
    sum_ads = sum_ad + POS_W'(slen_q[idx_q]);
    sum_all = sum_ads + POS_W'(rlen_q[idx_q]);
    env_ramp  = 1'b0;
    env_hold  = 1'b0;
    env_end   = 1'b0;
    env_off   = SEG_BITS'(cur_p);
    env_len   = alen_q[idx_q];
    env_mag   = peak_q[idx_q];
    env_start = '0;
    env_neg   = 1'b0;
    priority if (cur_p < POS_W'(alen_q[idx_q])) begin
      env_ramp = 1'b1;
    end else if (cur_p < sum_ad) begin
      env_ramp  = 1'b1;
      env_off   = SEG_BITS'(cur_p - POS_W'(alen_q[idx_q]));
      env_len   = dlen_q[idx_q];
      env_start = peak_q[idx_q];
      env_neg   = base_q[idx_q] < peak_q[idx_q];
      env_mag   = env_neg ? peak_q[idx_q] - base_q[idx_q] : base_q[idx_q] - peak_q[idx_q];
    end else if (cur_p < sum_ads) begin
      env_hold = 1'b1;
    end else if (cur_p < sum_all) begin
      env_ramp  = 1'b1;
      env_off   = SEG_BITS'(cur_p - sum_ads);
      env_len   = rlen_q[idx_q];
      env_start = base_q[idx_q];
      env_mag   = base_q[idx_q];
      env_neg   = 1'b1;
    end else begin
      env_end = 1'b1;
    end
  end

  always_comb begin
    cur_ph = phase_q[idx_q];
    sk     = cur_ph[29 -: SB];
    tidx   = cur_ph[30] ? (SB + 1)'(avm_pkg::SINE_DEPTH) - {1'b0, sk} : {1'b0, sk};
    tval   = avm_pkg::SINE_TAB[tidx];
    amp_div = 15'(div_quot);
    smp_s  = sneg_q ? -ACC_W'(smag_q) : ACC_W'(smag_q);
    pmag   = prod_q[30:16];
    part_s = sneg_q ? -ACC_W'(pmag) : ACC_W'(pmag);
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_num   = mul_out;
    div_den   = DEN_W'(len_q);
    mul_a     = MUL_A_W'(off_q);
    mul_b     = 16'(mag_q);
    unique case (state_q)
      avm_pkg::ST_IDLE: begin
        div_num = NUM_W'(avm_pkg::SAMPLE_RATE);
        div_den = f_sat;
        if (accept) begin
          if (func_i == avm_pkg::FUNC_TICK) begin
            state_d = avm_pkg::ST_SCAN;
          end else if (start_ok) begin
            div_start = 1'b1;
            state_d   = avm_pkg::ST_RATE_DIV;
          end
        end
      end
      avm_pkg::ST_RATE_DIV: begin
        div_num = NUM_W'(32'hFFFF_FFFF);
        div_den = div_quot[DEN_W-1:0];
        if (div_done) begin
          div_start = 1'b1;
          state_d   = avm_pkg::ST_STEP_DIV;
        end
      end
      avm_pkg::ST_STEP_DIV: begin
        if (div_done) state_d = avm_pkg::ST_IDLE;
      end
      avm_pkg::ST_SCAN: begin
        if (active_q[idx_q]) state_d = avm_pkg::ST_ENV;
        else if (last_voice) state_d = avm_pkg::ST_OUT;
      end
      avm_pkg::ST_ENV: begin
        if (env_ramp) state_d = avm_pkg::ST_ENV_MUL;
        else if (env_hold) state_d = avm_pkg::ST_WAVE;
        else if (last_voice) state_d = avm_pkg::ST_OUT;
        else state_d = avm_pkg::ST_SCAN;
      end
      avm_pkg::ST_ENV_MUL: begin
        div_start = 1'b1;
        state_d   = avm_pkg::ST_ENV_DIV;
      end
      avm_pkg::ST_ENV_DIV: begin
        if (div_done) state_d = avm_pkg::ST_WAVE;
      end
      avm_pkg::ST_WAVE: begin
        mul_a = MUL_A_W'(amp_q);
        mul_b = 16'(tval);
        if (shape_q[idx_q] == avm_pkg::WAVE_SINE) state_d = avm_pkg::ST_SINE;
        else state_d = avm_pkg::ST_PAN;
      end
      avm_pkg::ST_SINE: state_d = avm_pkg::ST_PAN;
      avm_pkg::ST_PAN: begin
        mul_a   = MUL_A_W'(smag_q);
        mul_b   = weight_q[idx_q];
        state_d = avm_pkg::ST_ACCUM;
      end
      avm_pkg::ST_ACCUM: begin
        state_d = last_voice ? avm_pkg::ST_OUT : avm_pkg::ST_SCAN;
      end
      avm_pkg::ST_OUT: state_d = avm_pkg::ST_IDLE;
      default: state_d = avm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= avm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = state_q != avm_pkg::ST_IDLE;

  // control state and voice progress
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      strobe_q <= 1'b0;
      for (int v = 0; v < VOICES; v++) begin
        active_q[v] <= 1'b0;
        pos_q[v]    <= '0;
        phase_q[v]  <= '0;
      end
    end else begin
      strobe_q <= state_q == avm_pkg::ST_OUT;
      unique case (state_q)
        avm_pkg::ST_IDLE: begin
          if (accept && func_i == avm_pkg::FUNC_TICK) begin
            idx_q <= '0;
          end else if (accept && start_ok) begin
            idx_q           <= VIDX_W'(voice_i);
            active_q[VIDX_W'(voice_i)] <= 1'b1;
            pos_q[VIDX_W'(voice_i)]    <= '0;
            phase_q[VIDX_W'(voice_i)]  <= '0;
          end
        end
        avm_pkg::ST_SCAN: begin
          if (!active_q[idx_q] && !last_voice) idx_q <= idx_q + 1'b1;
        end
        avm_pkg::ST_ENV: begin
          if (env_end) begin
            active_q[idx_q] <= 1'b0;
            pos_q[idx_q]    <= '0;
            if (!last_voice) idx_q <= idx_q + 1'b1;
          end
        end
        avm_pkg::ST_ACCUM: begin
          phase_q[idx_q] <= phase_q[idx_q] + step_q[idx_q];
          pos_q[idx_q]   <= pos_q[idx_q] + 1'b1;
          if (!last_voice) idx_q <= idx_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      avm_pkg::ST_IDLE: begin
        accl_q <= '0;
        accr_q <= '0;
        if (accept && func_i == avm_pkg::FUNC_START && start_ok) begin
          shape_q[VIDX_W'(voice_i)]  <= waveform_i;
          peak_q[VIDX_W'(voice_i)]   <= peak_i;
          base_q[VIDX_W'(voice_i)]   <= base_i;
          alen_q[VIDX_W'(voice_i)]   <= SEG_BITS'(attack_len_i);
          dlen_q[VIDX_W'(voice_i)]   <= SEG_BITS'(decay_len_i);
          slen_q[VIDX_W'(voice_i)]   <= SEG_BITS'(sustain_len_i);
          rlen_q[VIDX_W'(voice_i)]   <= SEG_BITS'(release_len_i);
          weight_q[VIDX_W'(voice_i)] <= weight_in;
        end
      end
      avm_pkg::ST_STEP_DIV: begin
        if (div_done) step_q[idx_q] <= div_quot[31:0];
      end
      avm_pkg::ST_ENV: begin
        off_q  <= env_off;
        len_q  <= env_len;
        mag_q  <= env_mag;
        env0_q <= env_start;
        neg_q  <= env_neg;
        amp_q  <= base_q[idx_q];
      end
      avm_pkg::ST_ENV_DIV: begin
        if (div_done) amp_q <= neg_q ? env0_q - amp_div : env0_q + amp_div;
      end
      avm_pkg::ST_WAVE: begin
        prod_q <= mul_out;
        smag_q <= amp_q;
        sneg_q <= cur_ph[31];
      end
      avm_pkg::ST_SINE: begin
        smag_q <= prod_q[29:15];
      end
      avm_pkg::ST_PAN: begin
        prod_q <= mul_out;
      end
      avm_pkg::ST_ACCUM: begin
        accr_q <= accr_q + part_s;
        accl_q <= accl_q + smp_s - part_s;
      end
      avm_pkg::ST_OUT: begin
        if (accl_q > ACC_W'(32767)) left_q <= 16'sd32767;
        else if (accl_q < -ACC_W'(32768)) left_q <= -16'sd32768;
        else left_q <= 16'(accl_q);
        if (accr_q > ACC_W'(32767)) right_q <= 16'sd32767;
        else if (accr_q < -ACC_W'(32768)) right_q <= -16'sd32768;
        else right_q <= 16'(accr_q);
      end
      default: ;
    endcase
  end

  assign result_valid_o = strobe_q;
  assign left_sample_o  = left_q;
  assign right_sample_o = right_q;

`ifndef SYNTH
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i == avm_pkg::FUNC_TICK) |=> busy)
    else $error("tick transfer did not start the voice walk");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == avm_pkg::ST_RATE_DIV || state_q == avm_pkg::ST_STEP_DIV ||
                  state_q == avm_pkg::ST_ENV_DIV))
    else $error("divider finished outside a wait state");
`endif

endmodule
